>>> rtl/imhq_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types of the indexed min-heap queue.
// No dependencies.
package imhq_pkg;

	localparam int VID_W = 8;
	localparam int NUM_VERTICES = 256;

	localparam logic [1:0] CMD_CLEAR    = 2'd0;
	localparam logic [1:0] CMD_LOAD     = 2'd1;
	localparam logic [1:0] CMD_EXTRACT  = 2'd2;
	localparam logic [1:0] CMD_DECREASE = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_EMPTY  = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;
	localparam logic [1:0] ST_ABSENT = 2'd3;

	typedef enum logic [2:0] {RA_ROOT, RA_LAST, RA_LEFT, RA_RIGHT, RA_PARENT} rd_sel_t;
	typedef enum logic [2:0] {WR_NEW, WR_KEY, WR_E, WR_CHILD, WR_RD} wr_sel_t;
	typedef enum logic [1:0] {E_HOLD, E_RD, E_IN} e_sel_t;
	typedef enum logic [2:0] {K_HOLD, K_ZERO, K_POS, K_CHILD, K_PARENT} k_sel_t;

	typedef struct packed {
		logic     capture;
		logic     clear_all;
		logic     load_new;
		logic     extract_root;
		rd_sel_t  rd_sel;
		logic     wr_en;
		wr_sel_t  wr_sel;
		e_sel_t   e_sel;
		k_sel_t   k_sel;
		logic     child_left;
		logic     child_right;
		logic     st_ld;
		logic [1:0] st_val;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       present;
		logic       full;
		logic       empty;
		logic       count_one;
		logic       left_ok;
		logic       right_ok;
		logic       k_zero;
		logic       pos_ok;
		logic       down_go;
		logic       up_go;
		logic       out_free;
	} dp_stat_t;

endpackage

>>> rtl/imhq_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces of the indexed min-heap queue.
// No dependencies.
interface imhq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  vertex_id;
	logic [31:0] new_key;
	modport source(output valid, command, vertex_id, new_key, input ready);
	modport sink(input valid, command, vertex_id, new_key, output ready);
endinterface

interface imhq_rsp_if;
	logic        valid;
	logic        ready;
	logic [7:0]  vertex_out;
	logic [31:0] key_out;
	logic [1:0]  status;
	logic [8:0]  entry_count;
	modport source(output valid, vertex_out, key_out, status, entry_count, input ready);
	modport sink(input valid, vertex_out, key_out, status, entry_count, output ready);
endinterface

>>> rtl/imhq_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer of the indexed min-heap queue.
// Depends on imhq_pkg.
module imhq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  imhq_pkg::dp_stat_t stat,
	output imhq_pkg::dp_cmd_t  cmd
);
	import imhq_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DECODE = 4'd1;
	localparam logic [3:0] S_LOADP  = 4'd2;
	localparam logic [3:0] S_EXR    = 4'd3;
	localparam logic [3:0] S_EXL    = 4'd4;
	localparam logic [3:0] S_DN_L   = 4'd5;
	localparam logic [3:0] S_DN_R   = 4'd6;
	localparam logic [3:0] S_DN_C   = 4'd7;
	localparam logic [3:0] S_DN_D   = 4'd8;
	localparam logic [3:0] S_DECP   = 4'd9;
	localparam logic [3:0] S_UP_A   = 4'd10;
	localparam logic [3:0] S_UP_B   = 4'd11;
	localparam logic [3:0] S_FINISH = 4'd12;

	logic [3:0] state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.rd_sel = RA_ROOT;
		cmd.wr_sel = WR_E;
		cmd.e_sel = E_HOLD;
		cmd.k_sel = K_HOLD;
		cmd.st_val = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				cmd.rd_sel = RA_ROOT;
				cmd.st_ld = 1'b1;
				unique case (stat.cmd)
					CMD_CLEAR: begin
						cmd.clear_all = 1'b1;
						state_d = S_FINISH;
					end
					CMD_LOAD: begin
						if (stat.present) begin
							state_d = S_LOADP;
						end else if (stat.full) begin
							cmd.st_val = ST_FULL;
							state_d = S_FINISH;
						end else begin
							cmd.load_new = 1'b1;
							cmd.wr_en = 1'b1;
							cmd.wr_sel = WR_NEW;
							state_d = S_FINISH;
						end
					end
					CMD_EXTRACT: begin
						if (stat.empty) begin
							cmd.st_val = ST_EMPTY;
							state_d = S_FINISH;
						end else begin
							state_d = S_EXR;
						end
					end
					default: begin
						if (!stat.present) begin
							cmd.st_val = ST_ABSENT;
							state_d = S_FINISH;
						end else begin
							state_d = S_DECP;
						end
					end
				endcase
			end
			S_LOADP: begin
				cmd.wr_en = 1'b1;
				cmd.wr_sel = WR_KEY;
				state_d = S_FINISH;
			end
			S_EXR: begin
				cmd.extract_root = 1'b1;
				cmd.rd_sel = RA_LAST;
				state_d = stat.count_one ? S_FINISH : S_EXL;
			end
			S_EXL: begin
				cmd.e_sel = E_RD;
				cmd.k_sel = K_ZERO;
				state_d = S_DN_L;
			end
			S_DN_L: begin
				cmd.rd_sel = RA_LEFT;
				if (!stat.left_ok) begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = WR_E;
					state_d = S_FINISH;
				end else begin
					state_d = S_DN_R;
				end
			end
			S_DN_R: begin
				cmd.child_left = 1'b1;
				cmd.rd_sel = RA_RIGHT;
				state_d = stat.right_ok ? S_DN_C : S_DN_D;
			end
			S_DN_C: begin
				cmd.child_right = 1'b1;
				state_d = S_DN_D;
			end
			S_DN_D: begin
				cmd.wr_en = 1'b1;
				if (stat.down_go) begin
					cmd.wr_sel = WR_CHILD;
					cmd.k_sel = K_CHILD;
					state_d = S_DN_L;
				end else begin
					cmd.wr_sel = WR_E;
					state_d = S_FINISH;
				end
			end
			S_DECP: begin
				if (stat.pos_ok) begin
					cmd.e_sel = E_IN;
					cmd.k_sel = K_POS;
					state_d = S_UP_A;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_UP_A: begin
				cmd.rd_sel = RA_PARENT;
				if (stat.k_zero) begin
					cmd.wr_en = 1'b1;
					cmd.wr_sel = WR_E;
					state_d = S_FINISH;
				end else begin
					state_d = S_UP_B;
				end
			end
			S_UP_B: begin
				cmd.wr_en = 1'b1;
				if (stat.up_go) begin
					cmd.wr_sel = WR_RD;
					cmd.k_sel = K_PARENT;
					state_d = S_UP_A;
				end else begin
					cmd.wr_sel = WR_E;
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/imhq_dp.sv
`timescale 1ns / 1ps
// Heap storage, position map, present bits and result register.
// Depends on imhq_pkg and imhq_if.
module imhq_dp #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	imhq_req_if.sink           req,
	imhq_rsp_if.source         rsp,
	input  imhq_pkg::dp_cmd_t  cmd,
	output imhq_pkg::dp_stat_t stat
);
	import imhq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [1:0]           cmd_q;
	logic [VID_W-1:0]     vid_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CW-1:0]        count_q;
	logic [NUM_VERTICES-1:0] present_q;
	logic [AW-1:0]        k_q, ci_q;
	logic [VID_W-1:0]     ev_q, cv_q, res_v_q, o_v_q;
	logic [KEY_WIDTH-1:0] ek_q, ck_q, res_k_q, o_k_q;
	logic [1:0]           res_st_q, o_st_q;
	logic [CW-1:0]        o_cnt_q;
	logic                 out_valid_q;

	logic [VID_W-1:0]     hv_mem [CAPACITY];
	logic [KEY_WIDTH-1:0] hk_mem [CAPACITY];
	logic [AW-1:0]        pos_mem [NUM_VERTICES];
	logic [VID_W-1:0]     hv_rd;
	logic [KEY_WIDTH-1:0] hk_rd;
	logic [AW-1:0]        pos_rd;

	logic [AW+1:0] left_w, right_w;
	logic [AW-1:0] parent_w, last_w, ra;
	logic [AW-1:0] wa, pd;
	logic [VID_W-1:0] wv, pa;
	logic [KEY_WIDTH-1:0] wk;
	logic wv_en, p_en;

	assign left_w   = {1'b0, k_q, 1'b1};
	assign right_w  = {1'b0, k_q, 1'b0} + (AW+2)'(2);
	assign parent_w = (k_q - AW'(1)) >> 1;
	assign last_w   = AW'(count_q - CW'(1));

	always_comb begin
		unique case (cmd.rd_sel)
			RA_ROOT:   ra = '0;
			RA_LAST:   ra = last_w;
			RA_LEFT:   ra = left_w[AW-1:0];
			RA_RIGHT:  ra = right_w[AW-1:0];
			RA_PARENT: ra = parent_w;
			default:   ra = '0;
		endcase
	end

	always_comb begin
		wa = k_q;
		wv = ev_q;
		wk = ek_q;
		wv_en = 1'b1;
		p_en = 1'b1;
		unique case (cmd.wr_sel)
			WR_NEW: begin
				wa = AW'(count_q);
				wv = vid_q;
				wk = key_q;
			end
			WR_KEY: begin
				wa = pos_rd;
				wk = key_q;
				wv_en = 1'b0;
				p_en = 1'b0;
			end
			WR_E: begin
				wv = ev_q;
				wk = ek_q;
			end
			WR_CHILD: begin
				wv = cv_q;
				wk = ck_q;
			end
			WR_RD: begin
				wv = hv_rd;
				wk = hk_rd;
			end
			default: begin
				wv_en = 1'b0;
				p_en = 1'b0;
			end
		endcase
		pa = wv;
		pd = wa;
	end

	always_ff @(posedge clk) begin
		hv_rd <= hv_mem[ra];
		hk_rd <= hk_mem[ra];
		pos_rd <= pos_mem[vid_q];
		if (cmd.wr_en) begin
			hk_mem[wa] <= wk;
			if (wv_en) begin
				hv_mem[wa] <= wv;
			end
			if (p_en) begin
				pos_mem[pa] <= pd;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			cmd_q <= req.command;
			vid_q <= req.vertex_id;
			key_q <= KEY_WIDTH'(req.new_key);
			res_v_q <= '0;
			res_k_q <= '0;
		end
		if (cmd.extract_root) begin
			res_v_q <= hv_rd;
			res_k_q <= hk_rd;
		end
		if (cmd.st_ld) begin
			res_st_q <= cmd.st_val;
		end
		unique case (cmd.e_sel)
			E_RD: begin
				ev_q <= hv_rd;
				ek_q <= hk_rd;
			end
			E_IN: begin
				ev_q <= vid_q;
				ek_q <= key_q;
			end
			default: ;
		endcase
		unique case (cmd.k_sel)
			K_ZERO:   k_q <= '0;
			K_POS:    k_q <= pos_rd;
			K_CHILD:  k_q <= ci_q;
			K_PARENT: k_q <= parent_w;
			default: ;
		endcase
		if (cmd.child_left) begin
			cv_q <= hv_rd;
			ck_q <= hk_rd;
			ci_q <= left_w[AW-1:0];
		end
		if (cmd.child_right && !(ck_q < hk_rd)) begin
			cv_q <= hv_rd;
			ck_q <= hk_rd;
			ci_q <= right_w[AW-1:0];
		end
		if (cmd.out_load) begin
			o_v_q <= res_v_q;
			o_k_q <= res_k_q;
			o_st_q <= res_st_q;
			o_cnt_q <= count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			present_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clear_all) begin
				count_q <= '0;
				present_q <= '0;
			end else if (cmd.load_new) begin
				count_q <= count_q + CW'(1);
				present_q[vid_q] <= 1'b1;
			end else if (cmd.extract_root) begin
				count_q <= count_q - CW'(1);
				present_q[hv_rd] <= 1'b0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.cmd       = cmd_q;
	assign stat.present   = present_q[vid_q];
	assign stat.full      = (count_q >= CW'(CAPACITY));
	assign stat.empty     = (count_q == '0);
	assign stat.count_one = (count_q == CW'(1));
	assign stat.left_ok   = (left_w < (AW+2)'(count_q));
	assign stat.right_ok  = (right_w < (AW+2)'(count_q));
	assign stat.k_zero    = (k_q == '0);
	assign stat.pos_ok    = (CW'(pos_rd) < count_q);
	assign stat.down_go   = (ek_q > ck_q);
	assign stat.up_go     = (ek_q < hk_rd);
	assign stat.out_free  = !out_valid_q || rsp.ready;

	assign rsp.valid       = out_valid_q;
	assign rsp.vertex_out  = o_v_q;
	assign rsp.key_out     = 32'(o_k_q);
	assign rsp.status      = o_st_q;
	assign rsp.entry_count = 9'(o_cnt_q);

endmodule

>>> rtl/indexed_min_heap_queue.sv
`timescale 1ns / 1ps
// Top level of the indexed min-heap queue: sequencer plus datapath.
// Depends on imhq_pkg, imhq_if, imhq_ctrl and imhq_dp.

// One request is handled at a time and always gives one response. Clear, a load of a new
// vertex and any refused command are answered from the decode step; a key rewrite of a
// present vertex adds one write step. Extract and decrease-key walk the heap through a
// heap memory with one read port, one write port and registered reads. Each level of
// sift-down reads the left child, then the right child if there is one, compares and
// writes; each level of sift-up reads the parent, compares and writes. The next request
// can be taken in the same cycle as the response appears; the response register frees the
// request side while a response waits to be taken. No clearing pass is needed after reset.
module indexed_min_heap_queue #(
	parameter int CAPACITY  = 256,
	parameter int KEY_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	imhq_req_if.sink   req,
	imhq_rsp_if.source rsp
);
	import imhq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	imhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	imhq_dp #(
		.CAPACITY (CAPACITY),
		.KEY_WIDTH(KEY_WIDTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp),
		.cmd   (cmd),
		.stat  (stat)
	);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while one is in progress");

	a_fail_no_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_OK |-> rsp.vertex_out == '0 && rsp.key_out == '0)
		else $error("failed command returned a vertex");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.empty |-> !stat.full)
		else $error("heap count out of range");

endmodule
